// ===== sv/nmeacs_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker package
// Character codes, sentence phase, result bundle and hex digit decode shared
// by the checker core and the top level.
// ----------------------------------------------------------------------------
package nmeacs_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_BODY,
		PH_HEX
	} phase_t;

	// One result per character
	typedef struct packed {
		logic [7:0]  echo_byte;
		logic [4:0]  field_number;
		logic        is_separator;
		logic        in_body;
		logic        sentence_end;
		logic        checksum_ok;
		logic [7:0]  computed_sum;
		logic [7:0]  received_sum;
		logic [15:0] bad_sentences;
	} res_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	// Decode one hex digit, either case
	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t h;
		h.ok  = 1'b0;
		h.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.ok  = 1'b1;
			h.val = 4'(c - 8'h57);
		end
		return h;
	endfunction

endpackage

// ===== sv/nmeacs_core.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checker core
// Holds the sentence state and works out one character's result and the next
// state in a single pass; the state advances when step is high.
// ----------------------------------------------------------------------------
module nmeacs_core
	import nmeacs_pkg::*;
#(
	parameter int MAX_FIELDS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_s1,
	output res_t       res
);

	localparam int CapInt = (MAX_FIELDS - 1 > 31) ? 31 : MAX_FIELDS - 1;
	localparam logic [4:0] CommaCap = 5'(CapInt);

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [4:0]  comma_q, comma_d;
	logic [7:0]  hex_q, hex_d;
	logic [1:0]  digits_q, digits_d;
	logic [15:0] fail_q, fail_d;
	logic        sep, body, fin, ok, bump;
	hex_t        hd;

	// Next state and result for the character in the input register
	always_comb begin
		phase_d  = phase_q;
		xor_d    = xor_q;
		comma_d  = comma_q;
		hex_d    = hex_q;
		digits_d = digits_q;
		sep      = 1'b0;
		body     = 1'b0;
		fin      = 1'b0;
		ok       = 1'b0;
		bump     = 1'b0;
		hd       = hex_digit(data_s1);
		if (data_s1 == CH_DOLLAR) begin
			phase_d  = PH_BODY;
			xor_d    = 8'd0;
			comma_d  = 5'd0;
			hex_d    = 8'd0;
			digits_d = 2'd0;
		end else begin
			case (phase_q)
				PH_BODY: begin
					if (data_s1 == CH_LF) begin
						fin     = 1'b1;
						bump    = 1'b1;
						phase_d = PH_IDLE;
					end else if (data_s1 == CH_STAR) begin
						phase_d = PH_HEX;
					end else if (data_s1 != CH_CR) begin
						body  = 1'b1;
						xor_d = xor_q ^ data_s1;
						if (data_s1 == CH_COMMA) begin
							sep = 1'b1;
							if (comma_q < CommaCap)
								comma_d = comma_q + 5'd1;
						end
					end
				end
				PH_HEX: begin
					if (data_s1 == CH_LF) begin
						fin     = 1'b1;
						ok      = (digits_q != 2'd0) && (hex_q == xor_q);
						bump    = !ok;
						phase_d = PH_IDLE;
					end else if (hd.ok && digits_q < 2'd2) begin
						hex_d    = {hex_q[3:0], hd.val};
						digits_d = digits_q + 2'd1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		fail_d = (bump && fail_q != 16'hFFFF) ? fail_q + 16'd1 : fail_q;
	end

	// Assemble the result
	always_comb begin
		res.echo_byte     = data_s1;
		res.field_number  = comma_d;
		res.is_separator  = sep;
		res.in_body       = body;
		res.sentence_end  = fin;
		res.checksum_ok   = ok;
		res.computed_sum  = xor_d;
		res.received_sum  = hex_d;
		res.bad_sentences = fail_d;
	end

	// Hold sentence state; advance on each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			xor_q    <= 8'd0;
			comma_q  <= 5'd0;
			hex_q    <= 8'd0;
			digits_q <= 2'd0;
			fail_q   <= 16'd0;
		end else if (step) begin
			phase_q  <= phase_d;
			xor_q    <= xor_d;
			comma_q  <= comma_d;
			hex_q    <= hex_d;
			digits_q <= digits_d;
			fail_q   <= fail_d;
		end
	end

	a_ok_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.checksum_ok |-> res.sentence_end)
		else $error("checksum_ok without sentence end");

	a_dollar_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && data_s1 == CH_DOLLAR |=> phase_q == PH_BODY && xor_q == 8'd0
		&& comma_q == 5'd0 && digits_q == 2'd0)
		else $error("dollar did not restart the sentence");

	a_fail_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fail_q >= $past(fail_q))
		else $error("failure count went down");

	a_comma_capped: assert property (@(posedge clk) disable iff (!arst_n)
		comma_q <= CommaCap)
		else $error("comma count above cap");

endmodule

// ===== sv/nmea_sentence_checksum_and_field_index.sv =====
// ----------------------------------------------------------------------------
// NMEA sentence checksum and field index
// Input register, single-pass checker core and result register, taking one
// character per cycle while the result register is free or being emptied.
// ----------------------------------------------------------------------------
// Flow: an accepted character waits in the input register until the result
// register is free or being emptied; its result is then loaded there and offered.
// Throughput: one character per cycle while the receiver keeps taking results;
// set by the single-pass core between the input register and the result register.
// Reset: arst_n clears both valid flags, the sentence phase to idle and all
// running sums, counts and the failure count to zero.
module nmea_sentence_checksum_and_field_index
	import nmeacs_pkg::*;
#(
	parameter int MAX_FIELDS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  echo_byte,
	output logic [4:0]  field_number,
	output logic        is_separator,
	output logic        in_body,
	output logic        sentence_end,
	output logic        checksum_ok,
	output logic [7:0]  computed_sum,
	output logic [7:0]  received_sum,
	output logic [15:0] bad_sentences
);

	logic       valid_s1, valid_s2;
	logic [7:0] data_s1;
	res_t       res, res_s2;
	logic       load_s2, step;

	// Advance when the result register is free or being emptied
	assign load_s2  = !valid_s2 || out_ready;
	assign step     = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			data_s1 <= data_byte;
	end

	nmeacs_core #(
		.MAX_FIELDS(MAX_FIELDS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.data_s1 (data_s1),
		.res     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_s2 <= res;
	end

	assign out_valid     = valid_s2;
	assign echo_byte     = res_s2.echo_byte;
	assign field_number  = res_s2.field_number;
	assign is_separator  = res_s2.is_separator;
	assign in_body       = res_s2.in_body;
	assign sentence_end  = res_s2.sentence_end;
	assign checksum_ok   = res_s2.checksum_ok;
	assign computed_sum  = res_s2.computed_sum;
	assign received_sum  = res_s2.received_sum;
	assign bad_sentences = res_s2.bad_sentences;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// NMEA sentence checksum and field index testbench
// Drives character streams through the valid/ready input. Every accepted
// character runs through a local copy of the checker state. Each result
// transaction is compared field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module testbench;
	import nmeacs_pkg::*;

	localparam int MAX_FIELDS = 32;
	localparam logic [4:0] COMMA_CAP = (MAX_FIELDS - 1 > 31) ? 5'd31 : 5'(MAX_FIELDS - 1);
	localparam int HOLD_LEN = 200;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int TAIL_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  echo_byte;
	logic [4:0]  field_number;
	logic        is_separator;
	logic        in_body;
	logic        sentence_end;
	logic        checksum_ok;
	logic [7:0]  computed_sum;
	logic [7:0]  received_sum;
	logic [15:0] bad_sentences;

	// Local copy of the checker state
	phase_t      st_phase = PH_IDLE;
	logic [7:0]  run_xor = '0;
	logic [4:0]  commas = '0;
	logic [7:0]  hex_acc = '0;
	logic [1:0]  hex_count = '0;
	logic [15:0] fail_tally = '0;

	res_t pending_results[$];
	int   error_count = 0;
	int   chars_sent = 0;
	int   idle_cycles = 0;
	bit   sender_jitter = 1'b1;
	bit   sink_jitter = 1'b1;
	int   hold_token = 0;
	int   hold_seen = 0;
	int   hold_left = 0;

	nmea_sentence_checksum_and_field_index #(
		.MAX_FIELDS(MAX_FIELDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.echo_byte(echo_byte),
		.field_number(field_number),
		.is_separator(is_separator),
		.in_body(in_body),
		.sentence_end(sentence_end),
		.checksum_ok(checksum_ok),
		.computed_sum(computed_sum),
		.received_sum(received_sum),
		.bad_sentences(bad_sentences)
	);

	always #4 clk = ~clk;

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Advance the checker state by one character and return its result
	function automatic res_t predict_char(input logic [7:0] c);
		res_t r;
		bit   failed;
		int   nib;
		r = '0;
		failed = 1'b0;
		nib = -1;
		r.echo_byte = c;
		if (c == CH_DOLLAR) begin
			st_phase = PH_BODY;
			run_xor = '0;
			commas = '0;
			hex_acc = '0;
			hex_count = '0;
		end else if (st_phase == PH_BODY) begin
			if (c == CH_LF) begin
				r.sentence_end = 1'b1;
				failed = 1'b1;
				st_phase = PH_IDLE;
			end else if (c == CH_STAR) begin
				st_phase = PH_HEX;
			end else if (c != CH_CR) begin
				r.in_body = 1'b1;
				run_xor ^= c;
				if (c == CH_COMMA) begin
					r.is_separator = 1'b1;
					if (commas < COMMA_CAP)
						commas++;
				end
			end
		end else if (st_phase == PH_HEX) begin
			if (c == CH_LF) begin
				r.sentence_end = 1'b1;
				r.checksum_ok = (hex_count != 0) && (hex_acc == run_xor);
				failed = !r.checksum_ok;
				st_phase = PH_IDLE;
			end else begin
				if (c >= "0" && c <= "9")
					nib = c - "0";
				else if (c >= "A" && c <= "F")
					nib = c - "A" + 10;
				else if (c >= "a" && c <= "f")
					nib = c - "a" + 10;
				if (nib >= 0 && hex_count < 2) begin
					hex_acc = {hex_acc[3:0], 4'(nib)};
					hex_count++;
				end
			end
		end
		if (failed && fail_tally != 16'hFFFF)
			fail_tally++;
		r.field_number = commas;
		r.computed_sum = run_xor;
		r.received_sum = hex_acc;
		r.bad_sentences = fail_tally;
		return r;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 10)
			return 8'("0") + 8'(n);
		return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(n) - 8'd10;
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		$display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Offer one character, hold it until accepted, then record its result
	task automatic send_char(input logic [7:0] c);
		if (sender_jitter) begin
			while ($urandom_range(0, 99) < 6) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		data_byte <= c;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(predict_char(c));
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	// Drop valid and hold the sender until every predicted result has come
	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// One sentence with random content; most are well formed, some broken
	task automatic send_random_sentence();
		logic [7:0] sum;
		logic [7:0] b;
		logic [7:0] claimed;
		int kind;
		int len;
		int r;
		int ndig;
		kind = $urandom_range(0, 99);
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 45) : $urandom_range(0, 12);
		sum = '0;
		// noise between sentences, never a dollar
		if ($urandom_range(0, 99) < 20) begin
			repeat ($urandom_range(1, 3)) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_DOLLAR)
					b ^= 8'h40;
				send_char(b);
			end
		end
		send_char(CH_DOLLAR);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				b = CH_COMMA;
			end else if (r < 24) begin
				b = CH_CR;
			end else begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_DOLLAR || b == CH_STAR || b == CH_LF)
					b ^= 8'h40;
			end
			if (b != CH_CR)
				sum ^= b;
			send_char(b);
		end
		// cut short: the next dollar restarts
		if (kind >= 94)
			return;
		// missing asterisk
		if (kind >= 80 && kind < 88) begin
			send_char(CH_LF);
			return;
		end
		send_char(CH_STAR);
		if ($urandom_range(0, 99) < 15)
			send_char($urandom_range(0, 1) ? CH_STAR : 8'("z"));
		claimed = (kind < 70) ? sum : sum ^ 8'($urandom_range(1, 255));
		ndig = (kind >= 88) ? $urandom_range(0, 1) : 2;
		if (ndig == 2)
			send_char(hex_char(claimed[7:4]));
		if (ndig >= 1)
			send_char(hex_char(claimed[3:0]));
		if ($urandom_range(0, 99) < 10)
			send_char(hex_char(4'($urandom_range(0, 15))));
		send_char(CH_LF);
	endtask

	// Idle characters, each special case of the sentence grammar
	task automatic test_directed_cases();
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CH_LF);
		// comma, lower case digit, junk and surplus digit after the asterisk
		send_char(CH_DOLLAR);
		send_text(",*2g*cc");
		send_char(CH_LF);
		// carriage return ignored, line feed without asterisk
		send_char(CH_DOLLAR);
		send_char(CH_CR);
		send_char(CH_LF);
		// asterisk with no digit
		send_char(CH_DOLLAR);
		send_char(CH_STAR);
		send_char(CH_LF);
		// single digit compared alone
		send_char(CH_DOLLAR);
		send_text("*0");
		send_char(CH_LF);
		// restart mid sentence, upper case digit
		send_char(CH_DOLLAR);
		send_char(CH_DOLLAR);
		send_text("K*4B");
		send_char(CH_LF);
	endtask

	// Run the comma count past its ceiling
	task automatic test_field_saturation();
		send_char(CH_DOLLAR);
		repeat (40)
			send_char(CH_COMMA);
		send_text("*00");
		send_char(CH_LF);
	endtask

	// Back-to-back traffic with no idling on either side
	task automatic test_full_rate();
		int stop_at;
		sender_jitter = 1'b0;
		sink_jitter = 1'b0;
		stop_at = chars_sent + 150;
		while (chars_sent < stop_at)
			send_random_sentence();
		sender_jitter = 1'b1;
		sink_jitter = 1'b1;
	endtask

	// Stall the receiver long enough to fill the block and stall the input
	task automatic test_output_hold_off();
		int stop_at;
		hold_token++;
		stop_at = chars_sent + 80;
		while (chars_sent < stop_at)
			send_random_sentence();
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int stop_at;
		stop_at = chars_sent + 880;
		while (chars_sent < stop_at)
			send_random_sentence();
	endtask

	initial begin
		wait (arst_n);
		@(posedge clk);
		test_directed_cases();
		test_field_saturation();
		wait_for_results();
		test_full_rate();
		test_output_hold_off();
		test_random_traffic();
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stalls, a long hold-off on request
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen = hold_token;
			hold_left = HOLD_LEN;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (sink_jitter) begin
			out_ready <= ($urandom_range(0, 99) >= 6);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		res_t seen;
		res_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {echo_byte, field_number, is_separator, in_body, sentence_end,
				checksum_ok, computed_sum, received_sum, bad_sentences};
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected result, echo_byte", 16'(seen.echo_byte), '0);
			end else begin
				want = pending_results.pop_front();
				if (seen.echo_byte !== want.echo_byte)
					flag_mismatch("echo_byte", 16'(seen.echo_byte),
						16'(want.echo_byte));
				if (seen.field_number !== want.field_number)
					flag_mismatch("field_number", 16'(seen.field_number),
						16'(want.field_number));
				if (seen.is_separator !== want.is_separator)
					flag_mismatch("is_separator", 16'(seen.is_separator),
						16'(want.is_separator));
				if (seen.in_body !== want.in_body)
					flag_mismatch("in_body", 16'(seen.in_body), 16'(want.in_body));
				if (seen.sentence_end !== want.sentence_end)
					flag_mismatch("sentence_end", 16'(seen.sentence_end),
						16'(want.sentence_end));
				if (seen.checksum_ok !== want.checksum_ok)
					flag_mismatch("checksum_ok", 16'(seen.checksum_ok),
						16'(want.checksum_ok));
				if (seen.computed_sum !== want.computed_sum)
					flag_mismatch("computed_sum", 16'(seen.computed_sum),
						16'(want.computed_sum));
				if (seen.received_sum !== want.received_sum)
					flag_mismatch("received_sum", 16'(seen.received_sum),
						16'(want.received_sum));
				if (seen.bad_sentences !== want.bad_sentences)
					flag_mismatch("bad_sentences", seen.bad_sentences, want.bad_sentences);
			end
		end
	end

	// End the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
